// ===== rtl/bpd_pkg.sv =====
// shared types, constants and code point helpers for the byte-level piece decoder
`timescale 1ns / 1ps
`default_nettype none

package bpd_pkg;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // results one input byte can cause at most
  localparam int unsigned MaxRes = 3;

  // utf-8 lead classes
  localparam logic [7:0] MaskLead2 = 8'he0;
  localparam logic [7:0] CodeLead2 = 8'hc0;
  localparam logic [7:0] MaskLead3 = 8'hf0;
  localparam logic [7:0] CodeLead3 = 8'he0;
  localparam logic [7:0] MaskLead4 = 8'hf8;
  localparam logic [7:0] CodeLead4 = 8'hf0;

  // byte-level table bounds
  localparam logic [7:0] PrintLo   = 8'd33;
  localparam logic [7:0] PrintHi   = 8'd126;
  localparam logic [7:0] LatinLo   = 8'd161;
  localparam logic [7:0] LatinHi   = 8'd172;
  localparam logic [7:0] LatinLo2  = 8'd174;
  localparam logic [7:0] ExclLast1 = 8'd32;
  localparam logic [7:0] ExclLast2 = 8'd66;
  localparam logic [7:0] ExclLast3 = 8'd67;
  localparam logic [7:0] ExclOfs2  = 8'd94;
  localparam logic [7:0] SoftHyph  = 8'd173;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } bpd_map_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [1:0]             nres;      // results in this entry, 1..3
    logic                   has_byte;  // 0 only for the empty end marker
    logic                   done;      // entry closes a piece
  } bpd_entry_t;

  // continuation bytes a lead calls for, 0 for a byte standing on its own
  function automatic logic [1:0] extra_bytes(input logic [7:0] c);
    logic [1:0] k;
    k = 2'd0;
    if (!c[7]) k = 2'd0;
    else if ((c & MaskLead2) == CodeLead2) k = 2'd1;
    else if ((c & MaskLead3) == CodeLead3) k = 2'd2;
    else if ((c & MaskLead4) == CodeLead4) k = 2'd3;
    return k;
  endfunction

  // code point back to raw byte
  function automatic bpd_map_t map_cp(input logic [20:0] cp);
    bpd_map_t   r;
    logic [7:0] lo;
    lo      = cp[7:0];
    r.ok    = 1'b0;
    r.value = 8'd0;
    if (cp[20:8] == 13'd0) begin
      r.value = lo;
      r.ok    = (lo >= PrintLo && lo <= PrintHi) || (lo >= LatinLo && lo <= LatinHi) ||
                (lo >= LatinLo2);
    end else if (cp[20:9] == 12'd0 && lo <= ExclLast3) begin
      r.ok = 1'b1;
      if (lo <= ExclLast1) r.value = lo;
      else if (lo <= ExclLast2) r.value = lo + ExclOfs2;
      else r.value = SoftHyph;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bpd_if.sv =====
// valid/ready channel interfaces for piece bytes in and raw bytes out
`timescale 1ns / 1ps
`default_nettype none

interface bpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       piece_last;

  modport source (output valid, output in_byte, output piece_last, input ready);
  modport sink (input valid, input in_byte, input piece_last, output ready);
endinterface

interface bpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       piece_done;

  modport source (output valid, output out_byte, output byte_valid, output piece_done,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input piece_done,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/bpd_front.sv =====
// front: utf-8 sequence tracking, code point mapping and result packing
`timescale 1ns / 1ps
`default_nettype none

module bpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                piece_last_i,
  output logic                in_ready_o,
  input  logic                q_full_i,
  output logic                push_o,
  output bpd_pkg::bpd_entry_t entry_o
);
  import bpd_pkg::*;

  logic [1:0]      need_q, need_d;
  logic [1:0]      held_q, held_d;
  logic [7:0]      lead_q, lead_d;
  logic [1:0][7:0] cont_q, cont_d;

  logic       fire;
  logic [1:0] k_in;
  logic [20:0] cp_done;
  bpd_map_t   slot [MaxRes];
  logic [MaxRes-1:0][7:0] packed_bytes;
  logic [1:0] n_res;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && !q_full_i;
  assign k_in       = extra_bytes(in_byte_i);

  // code point completed by this byte, k = held + 1
  always_comb begin
    unique case (held_q)
      2'd0:    cp_done = {10'd0, lead_q[4:0], in_byte_i[5:0]};
      2'd1:    cp_done = {5'd0, lead_q[3:0], cont_q[0][5:0], in_byte_i[5:0]};
      default: cp_done = {lead_q[2:0], cont_q[0][5:0], cont_q[1][5:0], in_byte_i[5:0]};
    endcase
  end

  always_comb begin
    need_d = need_q;
    held_d = held_q;
    lead_d = lead_q;
    cont_d = cont_q;
    for (int i = 0; i < MaxRes; i++) slot[i] = '0;

    if (need_q == 2'd0) begin
      if (k_in == 2'd0) begin
        slot[0] = map_cp({13'd0, in_byte_i});
      end else begin
        lead_d = in_byte_i;
        need_d = k_in;
        held_d = 2'd0;
      end
    end else if (held_q == 2'd2 || ({1'b0, held_q} + 3'd1) >= {1'b0, need_q}) begin
      slot[0] = map_cp(cp_done);
      need_d  = 2'd0;
      held_d  = 2'd0;
    end else begin
      cont_d[held_q[0]] = in_byte_i;
      held_d            = held_q + 2'd1;
    end

    if (piece_last_i) begin
      // cut-off sequence: lead stands raw, the rest is decoded afresh
      if (need_d != 2'd0) begin
        slot[0] = map_cp({13'd0, lead_d});
        if (held_d != 2'd0) begin
          if (held_d == 2'd2 && extra_bytes(cont_d[0]) == 2'd1) begin
            slot[1] = map_cp({10'd0, cont_d[0][4:0], cont_d[1][5:0]});
          end else begin
            slot[1] = map_cp({13'd0, cont_d[0]});
            if (held_d == 2'd2) slot[2] = map_cp({13'd0, cont_d[1]});
          end
        end
      end
      need_d = 2'd0;
      held_d = 2'd0;
    end
  end

  // squeeze out unmapped slots
  always_comb begin
    n_res        = 2'd0;
    packed_bytes = '0;
    for (int i = 0; i < MaxRes; i++) begin
      if (slot[i].ok) begin
        packed_bytes[n_res] = slot[i].value;
        n_res               = n_res + 2'd1;
      end
    end
  end

  always_comb begin
    entry_o.bytes    = packed_bytes;
    entry_o.has_byte = (n_res != 2'd0);
    entry_o.nres     = (n_res != 2'd0) ? n_res : 2'd1;
    entry_o.done     = piece_last_i;
  end

  assign push_o = fire && ((n_res != 2'd0) || piece_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 2'd0;
      held_q <= 2'd0;
    end else if (fire) begin
      need_q <= need_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      lead_q <= lead_d;
      cont_q <= cont_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpd_queue.sv =====
// short entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module bpd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bpd_pkg::bpd_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output bpd_pkg::bpd_entry_t head_o
);
  import bpd_pkg::*;

  bpd_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + QCntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

// ===== rtl/bpd_back.sv =====
// back: walks each queued entry out as single result transactions
`timescale 1ns / 1ps
`default_nettype none

module bpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  bpd_pkg::bpd_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic                piece_done_o
);
  import bpd_pkg::*;

  logic [1:0] idx_q;
  logic       fire;
  logic       at_end;

  assign at_end       = (idx_q == head_i.nres - 2'd1);
  assign out_valid_o  = !empty_i;
  assign fire         = out_valid_o && out_ready_i;
  assign pop_o        = fire && at_end;
  assign out_byte_o   = head_i.bytes[idx_q];
  assign byte_valid_o = head_i.has_byte;
  assign piece_done_o = head_i.done && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/byte_level_bpe_piece_decoder.sv =====
// top level of the byte-level bpe piece decoder
// the results of a byte are registered in the queue before the back offers them
// throughput: one byte per cycle unless the queue is full; n results make n transactions
// the two-entry queue lets input run on while a result waits on the output side
// reset: rst_ni asynchronous active low, clears sequence state, queue and output walk
`timescale 1ns / 1ps
`default_nettype none

module byte_level_bpe_piece_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpd_in_if.sink           piece_i,
  bpd_out_if.source        byte_o
);
  import bpd_pkg::*;

  // front to queue
  logic       push;
  bpd_entry_t push_entry;
  // queue status and head for the back
  logic       q_full;
  logic       q_empty;
  bpd_entry_t head;
  logic       pop;

  // front decodes one byte per transaction and packs up to three results into an entry
  bpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (piece_i.valid),
    .in_byte_i    (piece_i.in_byte),
    .piece_last_i (piece_i.piece_last),
    .in_ready_o   (piece_i.ready),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // decouples the two sides, ready to the input comes from the queue fill only
  bpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // back hands results out one transaction at a time, popping after the last
  bpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (byte_o.valid),
    .out_ready_i  (byte_o.ready),
    .out_byte_o   (byte_o.out_byte),
    .byte_valid_o (byte_o.byte_valid),
    .piece_done_o (byte_o.piece_done)
  );

endmodule

`default_nettype wire

// ===== rtl/bpd_checker.sv =====
// port-level checks on the piece decoder and their binding
`timescale 1ns / 1ps
`default_nettype none

module bpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       piece_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       piece_done_i
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(byte_valid_i) &&
    $stable(piece_done_i))
    else $error("result changed while stalled");

  // an empty result is only ever the end marker, carrying zero
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> piece_done_i && (out_byte_i == 8'd0))
    else $error("empty result outside piece end");

  // the end of a piece always yields a result in the next cycle on an idle output
  a_piece_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && piece_last_i && !out_valid_i |=> out_valid_i)
    else $error("piece end gave no result");

endmodule

bind byte_level_bpe_piece_decoder bpd_checker u_bpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (piece_i.valid),
  .in_ready_i   (piece_i.ready),
  .piece_last_i (piece_i.piece_last),
  .out_valid_i  (byte_o.valid),
  .out_ready_i  (byte_o.ready),
  .out_byte_i   (byte_o.out_byte),
  .byte_valid_i (byte_o.byte_valid),
  .piece_done_i (byte_o.piece_done)
);

`default_nettype wire

// ===== tb/bpd_decode_checker.sv =====
// checker for the piece decoder: predicts raw bytes from piece bytes and compares results
`timescale 1ns / 1ps

module bpd_decode_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bpd_in_if    piece_if,
  bpd_out_if   byte_if,
  output int   fail_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       done;
  } raw_result_t;

  // sequence state of the prediction
  logic [7:0]  lead_q;
  logic [7:0]  cont_q [2];
  logic [1:0]  need_q;
  logic [1:0]  held_q;

  raw_result_t step_res [$];
  raw_result_t raw_q [$];
  raw_result_t want;
  raw_result_t got;
  int          fails;
  int          checked;

  function automatic logic [1:0] seq_extra(input logic [7:0] c);
    if (!c[7]) return 2'd0;
    if (c[7:5] == 3'b110) return 2'd1;
    if (c[7:4] == 4'b1110) return 2'd2;
    if (c[7:3] == 5'b11110) return 2'd3;
    return 2'd0;
  endfunction

  function automatic logic [20:0] join_cp(input logic [7:0] lead, input logic [7:0] c0,
                                          input logic [7:0] c1, input logic [7:0] c2,
                                          input int k);
    if (k == 1) return 21'({lead[4:0], c0[5:0]});
    if (k == 2) return 21'({lead[3:0], c0[5:0], c1[5:0]});
    return {lead[2:0], c0[5:0], c1[5:0], c2[5:0]};
  endfunction

  // byte-level table back to the raw byte, unmapped points give nothing
  function automatic void take_cp(input logic [20:0] cp);
    int raw;
    int v;
    raw = -1;
    v   = int'(cp);
    if ((v >= 33 && v <= 126) || (v >= 161 && v <= 172) || (v >= 174 && v <= 255)) begin
      raw = v;
    end else if (v >= 256 && v <= 323) begin
      if (v - 256 <= 32) raw = v - 256;
      else if (v - 256 <= 66) raw = v - 256 + 94;
      else raw = 173;
    end
    if (raw >= 0 && step_res.size() < bpd_pkg::MaxRes) begin
      step_res.push_back('{value: raw[7:0], valid: 1'b1, done: 1'b0});
    end
  endfunction

  function automatic void clear_seq();
    lead_q    = 8'd0;
    cont_q[0] = 8'd0;
    cont_q[1] = 8'd0;
    need_q    = 2'd0;
    held_q    = 2'd0;
  endfunction

  function automatic void decode_piece_byte(input logic [7:0] b, input logic last);
    logic [7:0] c3 [3];
    logic [7:0] tail [5];
    int         tlen;
    int         i;
    int         k;
    step_res.delete();
    if (need_q == 2'd0) begin
      k = int'(seq_extra(b));
      if (k == 0) begin
        take_cp({13'd0, b});
      end else begin
        lead_q = b;
        need_q = k[1:0];
        held_q = 2'd0;
      end
    end else if (held_q >= 2 || held_q + 1 >= need_q) begin
      c3[0] = cont_q[0];
      c3[1] = cont_q[1];
      c3[2] = 8'd0;
      c3[held_q] = b;
      take_cp(join_cp(lead_q, c3[0], c3[1], c3[2], held_q + 1));
      clear_seq();
    end else begin
      cont_q[held_q[0]] = b;
      held_q = held_q + 2'd1;
    end

    if (last) begin
      // cut-off sequence: lead goes out raw, the rest is decoded again
      if (need_q != 2'd0) begin
        tail[0] = lead_q;
        tail[1] = cont_q[0];
        tail[2] = cont_q[1];
        tail[3] = 8'd0;
        tail[4] = 8'd0;
        tlen = held_q + 1;
        i = 0;
        while (i < tlen) begin
          k = int'(seq_extra(tail[i]));
          if (k == 0 || i + k >= tlen) begin
            take_cp({13'd0, tail[i]});
            i++;
          end else begin
            take_cp(join_cp(tail[i], tail[i+1], tail[i+2], tail[i+3], k));
            i += k + 1;
          end
        end
      end
      clear_seq();
      if (step_res.size() == 0) step_res.push_back('{value: 8'd0, valid: 1'b0, done: 1'b0});
      step_res[step_res.size()-1].done = 1'b1;
    end
    foreach (step_res[j]) raw_q.push_back(step_res[j]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_seq();
      raw_q.delete();
      fails     = 0;
      checked   = 0;
      fail_o    <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (piece_if.valid && piece_if.ready) begin
        decode_piece_byte(piece_if.in_byte, piece_if.piece_last);
      end
      if (byte_if.valid && byte_if.ready) begin
        got = '{value: byte_if.out_byte, valid: byte_if.byte_valid, done: byte_if.piece_done};
        if (raw_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%t: unexpected result byte=%02h valid=%b done=%b", $realtime,
                     got.value, got.valid, got.done);
          end
        end else begin
          want = raw_q.pop_front();
          checked++;
          if (got.value !== want.value || got.valid !== want.valid || got.done !== want.done) begin
            fails++;
            if (fails <= 10) begin
              $display("%t: result %0d mismatch: expected byte=%02h valid=%b done=%b,",
                       $realtime, checked, want.value, want.valid, want.done);
              $display("    got byte=%02h valid=%b done=%b",
                       got.value, got.valid, got.done);
            end
          end
        end
      end
      fail_o    <= fails;
      pending_o <= raw_q.size();
      checked_o <= checked;
    end
  end

endmodule

// ===== tb/byte_level_bpe_piece_decoder_tb.sv =====
// testbench top: drives piece bytes, stalls the result side and gives the verdict
`timescale 1ns / 1ps

module byte_level_bpe_piece_decoder_tb;

  localparam int HoldCycles  = 200;   // long receiver hold-off to fill the block
  localparam int IdleLimit   = 2000;  // watchdog, cycles without any transaction
  localparam int DrainCycles = 20;    // quiet time after the last expected result
  localparam int RandomBytes = 200;

  logic clk_i;
  logic rst_ni;

  bpd_in_if  piece_if ();
  bpd_out_if byte_if ();

  int fail_count;
  int pending;
  int checked;

  int         bytes_sent;
  int         pieces_sent;
  int         idle_cycles;
  bit         hold_req;
  bit         hold_done;
  logic [7:0] piece_buf [$];

  byte_level_bpe_piece_decoder u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .piece_i (piece_if),
    .byte_o  (byte_if)
  );

  bpd_decode_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .piece_if  (piece_if),
    .byte_if   (byte_if),
    .fail_o    (fail_count),
    .pending_o (pending),
    .checked_o (checked)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk_i) begin
    if ((piece_if.valid && piece_if.ready) || (byte_if.valid && byte_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               IdleLimit, pending);
      $display("[byte_level_bpe_piece_decoder] ERROR");
      $finish;
    end
  end

  // raw byte to its byte-level code point, the inverse of the table
  function automatic int raw_to_cp(input int b);
    if ((b >= 33 && b <= 126) || (b >= 161 && b <= 172) || b >= 174) return b;
    if (b <= 32) return 256 + b;
    if (b <= 160) return 256 + b - 94;
    return 323;  // soft hyphen is the last excluded byte
  endfunction

  // utf-8 encode one code point onto the piece buffer
  task automatic add_cp(input int cp);
    if (cp < 'h80) begin
      piece_buf.push_back(cp[7:0]);
    end else if (cp < 'h800) begin
      piece_buf.push_back(8'hc0 | cp[10:6]);
      piece_buf.push_back(8'h80 | cp[5:0]);
    end else if (cp < 'h10000) begin
      piece_buf.push_back(8'he0 | cp[15:12]);
      piece_buf.push_back(8'h80 | cp[11:6]);
      piece_buf.push_back(8'h80 | cp[5:0]);
    end else begin
      piece_buf.push_back(8'hf0 | cp[20:18]);
      piece_buf.push_back(8'h80 | cp[17:12]);
      piece_buf.push_back(8'h80 | cp[11:6]);
      piece_buf.push_back(8'h80 | cp[5:0]);
    end
  endtask

  // one byte transaction, with a random gap in front unless in a fast run
  int send_fast_left;
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (send_fast_left > 0) begin
      gap = 0;
      send_fast_left--;
    end else begin
      if ($urandom_range(0, 15) == 0) send_fast_left = $urandom_range(5, 25);
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      piece_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    piece_if.valid      <= 1'b1;
    piece_if.in_byte    <= b;
    piece_if.piece_last <= last;
    do @(posedge clk_i); while (!piece_if.ready);
    bytes_sent++;
  endtask

  // whole piece from the buffer, flag on the final byte
  task automatic send_piece();
    foreach (piece_buf[i]) send_byte(piece_buf[i], i == piece_buf.size() - 1);
    piece_buf.delete();
    pieces_sent++;
  endtask

  // mostly well-formed byte-level text, with foreign code points, noise and cut-off ends
  task automatic build_random_piece();
    int n_cp;
    int kind;
    n_cp = $urandom_range(1, 6);
    repeat (n_cp) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) add_cp(raw_to_cp($urandom_range(0, 255)));
      else if (kind < 15) add_cp($urandom_range(0, 'h7ff));
      else if (kind < 16) add_cp($urandom_range('h800, 'hffff));
      else if (kind < 17) add_cp($urandom_range('h10000, 'h1fffff));
      else piece_buf.push_back(8'($urandom_range(0, 255)));
    end
    // cut the tail short now and then so the piece ends mid-sequence
    if (piece_buf.size() > 1 && $urandom_range(0, 4) == 0) void'(piece_buf.pop_back());
  endtask

  // result side: random stalls, fast runs, and one long hold-off on request
  initial begin
    int gap;
    int fast_left;
    fast_left = 0;
    byte_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        byte_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (fast_left > 0) begin
        gap = 0;
        fast_left--;
      end else begin
        if ($urandom_range(0, 15) == 0) fast_left = $urandom_range(5, 25);
        gap = $urandom_range(0, 10);
      end
      if (gap > 0) begin
        byte_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      byte_if.ready <= 1'b1;
      do @(posedge clk_i); while (!byte_if.valid);
    end
  end

  // stimulus and verdict
  initial begin
    bytes_sent     = 0;
    pieces_sent    = 0;
    send_fast_left = 0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    idle_cycles    <= 0;
    rst_ni         <= 1'b0;
    piece_if.valid      <= 1'b0;
    piece_if.in_byte    <= 8'd0;
    piece_if.piece_last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single unmapped byte: only the empty end marker comes back
    piece_buf = '{8'h00};
    send_piece();
    // top raw byte, stray continuations, then a two-byte point for the space byte
    piece_buf = '{8'hff, 8'h80, 8'ha1, 8'hc4, 8'ha0};
    send_piece();
    // first excluded byte past 32, soft hyphen, out-of-table two-byte point,
    // three-byte euro sign (no result) and an invalid lead taken raw
    piece_buf = '{8'hc4, 8'ha1, 8'hc5, 8'h83, 8'hc5, 8'ha1, 8'he2, 8'h82, 8'hac, 8'hf8};
    send_piece();
    // four-byte point outside the table
    piece_buf = '{8'hf0, 8'h9f, 8'h98, 8'h80};
    send_piece();
    // three-byte lead cut off by the piece end
    piece_buf = '{8'he2, 8'h82};
    send_piece();
    // four-byte lead cut off, its held bytes form a two-byte point of their own
    piece_buf = '{8'hf0, 8'hc3, 8'ha9};
    send_piece();

    // random part, starting with the long output stall
    hold_req = 1'b1;
    while (bytes_sent < 25 + RandomBytes) begin
      build_random_piece();
      send_piece();
    end
    piece_if.valid <= 1'b0;

    // the count of outstanding results is registered in the checker and trails the last transaction
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d piece bytes in %0d pieces, %0d decoded results compared",
             bytes_sent, pieces_sent, checked);
    $display("directed table edges, cut-off and stray sequences, random stalls");
    $display("and one %0d-cycle output hold-off", HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("[byte_level_bpe_piece_decoder] OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", fail_count, pending);
      $display("[byte_level_bpe_piece_decoder] ERROR");
    end
    $finish;
  end

endmodule
